>>> hdl/rgb_to_hsl_top_defines.svh
// ---------------------------------------------------------------------------
// RGB to HSL assertion macros
// Shared concurrent assertion wrappers for the converter modules.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSL_TOP_DEFINES_SVH
`define RGB_TO_HSL_TOP_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define RTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RTH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/rth_pkg.sv
// ---------------------------------------------------------------------------
// RGB to HSL package
// Types and constants shared by the converter front end, cells and top.
// ---------------------------------------------------------------------------
package rth_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned QuotW   = 17;   // quotient bits, one per cell
  localparam int unsigned HueW    = 15;
  localparam int unsigned SatW    = 16;
  localparam int unsigned LightW  = 9;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 40;

  // Per-division state carried through the cell chain. The dq word starts
  // as the low dividend bits and fills up with quotient bits from the right.
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [QuotW-1:0] dq;
    logic [ChanW-1:0] den;
  } rth_div_t;

  typedef struct packed {
    rth_div_t            hue;
    rth_div_t            sat;
    logic [LightW-1:0]   lightness;
    logic                achromatic;
  } rth_pix_t;

endpackage

>>> hdl/rth_front.sv
// ---------------------------------------------------------------------------
// RGB to HSL front end
// Finds max, min, delta and sum, and sets up both divisions.
// ---------------------------------------------------------------------------
module rth_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [rth_pkg::InDataW-1:0]   data_i,   // red, green, blue from bit 0
  output logic                          valid_o,
  input  logic                          ready_i,
  output rth_pkg::rth_pix_t             data_o
);
  import rth_pkg::*;

  logic [ChanW-1:0]  red, green, blue, hi, lo, delta;
  logic [LightW-1:0] sum, sat_den_w;
  logic [10:0]       num;
  logic [14:0]       num15;
  logic [24:0]       hue_dvd;
  rth_pix_t          pix_d, pix_q;
  logic              valid_q;

  always_comb begin
    red   = data_i[7:0];
    green = data_i[15:8];
    blue  = data_i[23:16];
    hi = (red > green) ? red : green;
    if (blue > hi) hi = blue;
    lo = (red < green) ? red : green;
    if (blue < lo) lo = blue;
    delta = hi - lo;
    sum   = {1'b0, hi} + {1'b0, lo};
    sat_den_w = (sum > 9'd255) ? (9'd510 - sum) : sum;

    // Hue numerator: sector times delta plus the channel difference.
    if (hi == red) begin
      if (green >= blue) num = {3'b0, green - blue};
      else num = 11'(6 * delta) - {3'b0, blue - green};
    end else if (hi == green) begin
      num = {2'b0, delta, 1'b0} + {3'b0, blue} - {3'b0, red};
    end else begin
      num = {1'b0, delta, 2'b0} + {3'b0, red} - {3'b0, green};
    end

    // Dividend num * 3840 * 4; the extra factor four keeps the quotient
    // at the full cell count, and the two low bits are dropped at the end.
    num15   = {num, 4'b0} - {4'b0, num};
    hue_dvd = {num15, 10'b0};

    pix_d.hue.rem = hue_dvd[24:17];
    pix_d.hue.dq  = hue_dvd[16:0];
    pix_d.hue.den = delta;
    pix_d.sat.rem = {1'b0, delta[7:1]};
    pix_d.sat.dq  = {delta[0], 16'b0};
    pix_d.sat.den = sat_den_w[7:0];
    pix_d.lightness  = sum;
    pix_d.achromatic = (delta == '0);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = pix_q;

endmodule

>>> hdl/rth_div_cell.sv
// ---------------------------------------------------------------------------
// RGB to HSL division cell
// One restoring step for the hue and saturation quotients, registered.
// ---------------------------------------------------------------------------
`include "rgb_to_hsl_top_defines.svh"

module rth_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rth_pkg::rth_pix_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output rth_pkg::rth_pix_t data_o
);
  import rth_pkg::*;

  function automatic rth_div_t div_step(rth_div_t s);
    logic [ChanW:0] part;
    logic [ChanW:0] diff;
    logic           ge;
    rth_div_t       r;
    part = {s.rem, s.dq[QuotW-1]};
    diff = part - {1'b0, s.den};
    ge   = (part >= {1'b0, s.den});
    r.rem = ge ? diff[ChanW-1:0] : part[ChanW-1:0];
    r.dq  = {s.dq[QuotW-2:0], ge};
    r.den = s.den;
    return r;
  endfunction

  rth_pix_t pix_d, pix_q;
  logic     valid_q;

  always_comb begin
    pix_d     = data_i;
    pix_d.hue = div_step(data_i.hue);
    pix_d.sat = div_step(data_i.sat);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = pix_q;

  // The partial remainder must stay below the divisor for a chromatic pixel.
  `RTH_ASSERT(a_hue_rem_lt_den,
              valid_q && !pix_q.achromatic |-> pix_q.hue.rem < pix_q.hue.den,
              "hue remainder reached divisor")
  `RTH_ASSERT(a_sat_rem_lt_den,
              valid_q && !pix_q.achromatic |-> pix_q.sat.rem < pix_q.sat.den,
              "saturation remainder reached divisor")
  `RTH_ASSERT(a_hold_on_stall,
              valid_q && !ready_i |=> valid_q && $stable(pix_q),
              "cell contents changed while stalled")
  `RTH_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |-> !valid_q,
                     "cell holds a beat during reset")

endmodule

>>> hdl/rgb_to_hsl_top.sv
// ---------------------------------------------------------------------------
// RGB to HSL converter top level
// Streams 8-bit RGB pixels in and HSL results out, one pixel per clock unless the output stalls.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  tdata (from bit 0)                      tuser
//   s_axis    in         red[7:0] green[15:8] blue[23:16]        -
//   m_axis    out        hue[14:0] saturation[30:15]             achromatic
//                        lightness[39:31]
//
// Each pixel passes through one register in the front end (max, min,
// delta, sum, hue numerator) and one in each of the 17 division cells.
// A new pixel is taken, and each cell produces one quotient bit of the hue
// and of the saturation, every clock unless the output stalls.
// Reset empties the pipeline; there is no other state.
// Every stage has its own ready, so a stalled output only stops the stages
// that are full, and empty slots upstream still take new beats.
//
// Hue is computed as floor(num * 3840 / delta), with num the sector offset
// times delta plus the channel difference. The dividend is scaled by four so
// that the hue and saturation divisions both run for 17 steps; the two low
// quotient bits of the hue are dropped. Saturation is delta * 65536 divided
// by either the sum or 510 minus the sum, and a quotient of exactly 65536
// clamps to 65535. When all channels are equal, hue and saturation are
// forced to zero and tuser is set.
// ---------------------------------------------------------------------------
`include "rgb_to_hsl_top_defines.svh"

module rgb_to_hsl_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rth_pkg::InDataW-1:0]   s_axis_tdata,  // red, green, blue
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rth_pkg::OutDataW-1:0]  m_axis_tdata,  // hue, saturation, lightness
  output logic                          m_axis_tuser   // achromatic
);
  import rth_pkg::*;

  // Stage k feeds cell k; index QuotW is the last cell's output.
  rth_pix_t         stage_data  [QuotW+1];
  logic [QuotW:0]   stage_valid;
  logic [QuotW:0]   stage_ready;

  logic [HueW-1:0]  hue;
  logic [SatW-1:0]  saturation;

  rth_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .valid_o (stage_valid[0]),
    .ready_i (stage_ready[0]),
    .data_o  (stage_data[0])
  );

  for (genvar k = 0; k < QuotW; k++) begin : g_cell
    rth_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[k]),
      .ready_o (stage_ready[k]),
      .data_i  (stage_data[k]),
      .valid_o (stage_valid[k+1]),
      .ready_i (stage_ready[k+1]),
      .data_o  (stage_data[k+1])
    );
  end

  assign stage_ready[QuotW] = m_axis_tready;

  // The last cell's register is the output register.
  always_comb begin
    if (stage_data[QuotW].achromatic) begin
      hue        = '0;
      saturation = '0;
    end else begin
      hue        = stage_data[QuotW].hue.dq[QuotW-1:2];
      saturation = stage_data[QuotW].sat.dq[QuotW-1] ? {SatW{1'b1}}
                                                     : stage_data[QuotW].sat.dq[SatW-1:0];
    end
  end

  assign m_axis_tvalid = stage_valid[QuotW];
  assign m_axis_tdata  = {stage_data[QuotW].lightness, saturation, hue};
  assign m_axis_tuser  = stage_data[QuotW].achromatic;

  `RTH_ASSERT(a_hue_range, m_axis_tvalid |-> hue <= 15'd23039,
              "hue out of range")
  `RTH_ASSERT(a_achromatic_zero,
              m_axis_tvalid && m_axis_tuser |-> hue == '0 && saturation == '0,
              "achromatic pixel with nonzero hue or saturation")
  `RTH_ASSERT(a_lightness_range, m_axis_tvalid |-> stage_data[QuotW].lightness <= 9'd510,
              "lightness out of range")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RGB to HSL converter testbench
// Streams directed and random pixels through the converter while both the
// source and the sink pause at random. Each output beat is checked field by
// field against a pixel-level HSL predictor, in arrival order.
// ---------------------------------------------------------------------------
module tb;

  import rth_pkg::*;

  // Idle time at the end of a run, after every pending result has arrived.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned RandomPixels = 1030;
  localparam int unsigned MaxPrinted   = 40;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             drain;   // hold this pixel back until the pipeline is empty
  } pixel_req_t;

  typedef struct packed {
    logic [HueW-1:0]   hue;
    logic [SatW-1:0]   sat;
    logic [LightW-1:0] light;
    logic              achro;
  } hsl_t;

  typedef struct packed {
    hsl_t             res;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } hsl_due_t;

  logic                clk_i;
  logic                rst_ni        = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // red, green, blue
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // hue, saturation, lightness
  logic                m_axis_tuser;         // achromatic

  pixel_req_t  pixel_q[$];
  hsl_due_t    hsl_due_q[$];
  int unsigned beats_in  = 0;
  int unsigned beats_out = 0;
  int unsigned src_gap   = 0;
  int unsigned sink_gap  = 0;
  int unsigned quiet_cnt = 0;
  int unsigned err_cnt   = 0;

  wire s_fire = s_axis_tvalid && s_axis_tready;
  wire m_fire = m_axis_tvalid && m_axis_tready;

  rgb_to_hsl_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Integer HSL of one pixel. Hue is in 1/64 degree, saturation in Q0.16.
  function automatic hsl_t hsl_of(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                                  input logic [ChanW-1:0] b);
    int unsigned rd, gr, bl, hi, lo, delta, sum, divisor, num, q;
    hsl_t o;
    rd = r;
    gr = g;
    bl = b;
    hi = rd;
    if (gr > hi) hi = gr;
    if (bl > hi) hi = bl;
    lo = rd;
    if (gr < lo) lo = gr;
    if (bl < lo) lo = bl;
    delta   = hi - lo;
    sum     = hi + lo;
    o.hue   = '0;
    o.sat   = '0;
    o.light = sum[LightW-1:0];
    o.achro = (delta == 0);
    if (delta != 0) begin
      divisor = (sum > 255) ? 510 - sum : sum;
      if (divisor == 0) begin
        q = 65535;
      end else begin
        q = (delta << 16) / divisor;
        if (q > 65535) q = 65535;
      end
      o.sat = q[SatW-1:0];
      // Red wins ties for the max, then green. A red max with blue above
      // green lands in the top sector so the hue never goes negative.
      if (hi == rd) begin
        num = (gr >= bl) ? gr - bl : 6 * delta - (bl - gr);
      end else if (hi == gr) begin
        num = 2 * delta + bl - rd;
      end else begin
        num = 4 * delta + rd - gr;
      end
      q = (num * 3840) / delta;
      o.hue = q[HueW-1:0];
    end
    return o;
  endfunction

  // Mostly short pauses with the odd long one; none at all in calm stretches.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 48);
  endfunction

  task automatic note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MaxPrinted) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic add_px(input int unsigned r, input int unsigned g, input int unsigned b,
                        input bit drain);
    pixel_req_t p;
    p.red   = r[ChanW-1:0];
    p.green = g[ChanW-1:0];
    p.blue  = b[ChanW-1:0];
    p.drain = drain;
    pixel_q.push_back(p);
  endtask

  // Source side. A pixel marked for draining waits until every beat that
  // went in has come back out, counting the beats on this very edge.
  always @(posedge clk_i or negedge rst_ni) begin : drive_src
    pixel_req_t nxt;
    bit         pipe_empty;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_gap       <= 0;
      beats_in      <= 0;
    end else begin
      pipe_empty = (beats_in + s_fire) == (beats_out + m_fire);
      if (s_fire) beats_in <= beats_in + 1;
      if (s_axis_tvalid && !s_axis_tready) begin
        // The beat on the bus is held until it is taken.
      end else if (src_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap       <= src_gap - 1;
      end else if (pixel_q.size() != 0 && !(pixel_q[0].drain && !pipe_empty)) begin
        nxt = pixel_q.pop_front();
        s_axis_tdata  <= {nxt.blue, nxt.green, nxt.red};
        s_axis_tvalid <= 1'b1;
        src_gap       <= pick_gap(((beats_in / 97) % 3) == 0);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: predicts each accepted pixel, checks each result beat and
  // throttles tready.
  always @(posedge clk_i or negedge rst_ni) begin : watch_sink
    hsl_t     got;
    hsl_due_t due;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= 0;
      beats_out     <= 0;
    end else begin
      if (s_fire) begin
        due.res   = hsl_of(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]);
        due.red   = s_axis_tdata[7:0];
        due.green = s_axis_tdata[15:8];
        due.blue  = s_axis_tdata[23:16];
        hsl_due_q.push_back(due);
      end
      if (m_fire) begin
        beats_out <= beats_out + 1;
        got.hue   = m_axis_tdata[14:0];
        got.sat   = m_axis_tdata[30:15];
        got.light = m_axis_tdata[39:31];
        got.achro = m_axis_tuser;
        if (hsl_due_q.size() == 0) begin
          note_mismatch($sformatf("result beat with no pixel pending (tdata %h)",
                                  m_axis_tdata));
        end else begin
          due = hsl_due_q.pop_front();
          if (got.hue != due.res.hue)
            note_mismatch($sformatf("rgb %0d,%0d,%0d: hue %0d, expected %0d",
                                    due.red, due.green, due.blue, got.hue, due.res.hue));
          if (got.sat != due.res.sat)
            note_mismatch($sformatf("rgb %0d,%0d,%0d: saturation %0d, expected %0d",
                                    due.red, due.green, due.blue, got.sat, due.res.sat));
          if (got.light != due.res.light)
            note_mismatch($sformatf("rgb %0d,%0d,%0d: lightness %0d, expected %0d",
                                    due.red, due.green, due.blue, got.light, due.res.light));
          if (got.achro != due.res.achro)
            note_mismatch($sformatf("rgb %0d,%0d,%0d: achromatic %0d, expected %0d",
                                    due.red, due.green, due.blue, got.achro, due.res.achro));
        end
      end
      if (sink_gap != 0) begin
        m_axis_tready <= 1'b0;
        sink_gap      <= sink_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_fire || $urandom_range(0, 7) == 0)
          sink_gap <= pick_gap(((beats_out / 131) % 3) == 1);
      end
    end
  end

  // Ends a run in which neither side has moved a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || s_fire || m_fire) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt == QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : run_ctl
    int unsigned kind, v, w, r, g, b;

    // Reset falls at time zero, so the asynchronous clear sees a real edge
    // before the first clock.
    rst_ni <= 1'b0;

    // Directed pixels: grays, primaries, ties for the max, the wrap sector,
    // tiny and near-white sums, and full saturation.
    add_px(0, 0, 0, 1'b0);
    add_px(255, 255, 255, 1'b0);
    add_px(128, 128, 128, 1'b0);
    add_px(255, 0, 0, 1'b0);
    add_px(0, 255, 0, 1'b0);
    add_px(0, 0, 255, 1'b0);
    add_px(255, 255, 0, 1'b0);
    add_px(255, 0, 255, 1'b0);
    add_px(0, 255, 255, 1'b0);
    add_px(255, 0, 1, 1'b0);
    add_px(200, 10, 11, 1'b0);
    add_px(1, 0, 0, 1'b0);
    add_px(0, 1, 0, 1'b0);
    add_px(0, 0, 1, 1'b0);
    add_px(255, 254, 254, 1'b0);
    add_px(254, 255, 255, 1'b0);
    add_px(128, 0, 0, 1'b0);
    add_px(127, 128, 128, 1'b0);
    add_px(85, 170, 255, 1'b0);
    add_px(200, 100, 50, 1'b0);
    add_px(50, 100, 200, 1'b0);
    add_px(170, 85, 170, 1'b0);
    add_px(10, 20, 10, 1'b0);
    add_px(1, 1, 0, 1'b0);

    // Random pixels, biased toward grays, ties, extremes and small values.
    for (int i = 0; i < RandomPixels; i++) begin
      kind = $urandom_range(0, 9);
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
      case (kind)
        5: begin
          g = r;
          b = r;
        end
        6: begin
          v = $urandom_range(1, 255);
          w = $urandom_range(0, v - 1);
          case ($urandom_range(0, 2))
            0: begin r = v; g = v; b = w; end
            1: begin r = v; g = w; b = v; end
            default: begin r = w; g = v; b = v; end
          endcase
        end
        7: begin
          r = ($urandom_range(0, 1) != 0) ? 255 : 0;
          g = ($urandom_range(0, 2) == 0) ? g : (($urandom_range(0, 1) != 0) ? 254 : 1);
          b = ($urandom_range(0, 1) != 0) ? 255 : 0;
        end
        8: begin
          r = $urandom_range(0, 3);
          g = $urandom_range(0, 3);
          b = $urandom_range(0, 3);
        end
        9: begin
          v = $urandom_range(2, 253);
          r = v + $urandom_range(0, 2) - 1;
          g = v + $urandom_range(0, 2) - 1;
          b = v;
        end
        default: begin
        end
      endcase
      add_px(r, g, b, (i == 0) || ($urandom_range(0, 199) == 0));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pixel_q.size() != 0 || s_axis_tvalid || hsl_due_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);

    if (hsl_due_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", hsl_due_q.size()));
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> rgb_to_hsl_top.f
+incdir+hdl
hdl/rth_pkg.sv
hdl/rth_front.sv
hdl/rth_div_cell.sv
hdl/rgb_to_hsl_top.sv
bench/tb.sv
